### rtl/lpnd_pkg.sv
// Package for the length-prefixed NAL deframer: payload structs, codes,
// queue sizing and result helpers. No dependencies.
`default_nettype none

package lpnd_pkg;

    localparam int POSITION_BITS_DEF = 24;
    localparam int QUEUE_DEPTH       = 4;
    localparam int OFFSET_W          = 24;
    localparam int LENGTH_W          = 31;

    typedef enum logic [1:0] {
        K_UNIT    = 2'd0,
        K_INVALID = 2'd1,
        K_EXCEEDS = 2'd2,
        K_TRUNC   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        PH_PREFIX  = 3'b001,
        PH_PAYLOAD = 3'b010,
        PH_DISCARD = 3'b100
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_last;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          kind;
        logic [OFFSET_W-1:0] unit_offset;
        logic [LENGTH_W-1:0] unit_length;
        logic                forbidden_bit;
        logic [1:0]          ref_priority;
        logic [4:0]          unit_type;
        logic [OFFSET_W-1:0] remaining_bytes;
        logic                last;
    } t_result;

    typedef struct packed {
        logic    two;
        t_result r0;
        t_result r1;
    } t_pair;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

    function automatic logic [2:0] prefix_len(input logic [2:0] lfb);
        logic [2:0] l;
        priority if (lfb == 3'd0) begin
            l = 3'd1;
        end else if (lfb > 3'd4) begin
            l = 3'd4;
        end else begin
            l = lfb;
        end
        return l;
    endfunction

    function automatic t_result mk_result(input t_kind kind,
                                          input logic [OFFSET_W-1:0] offset,
                                          input logic [LENGTH_W-1:0] length,
                                          input logic [7:0] hdr,
                                          input logic [OFFSET_W-1:0] remaining);
        t_result r;
        r.kind            = kind;
        r.unit_offset     = offset;
        r.unit_length     = length;
        r.forbidden_bit   = hdr[7];
        r.ref_priority    = hdr[6:5];
        r.unit_type       = hdr[4:0];
        r.remaining_bytes = remaining;
        r.last            = 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/lpnd_front.sv
// Front part: accepts packet bytes, tracks prefix/payload/discard phase and
// emits one- or two-result pairs at unit or packet end. Depends on lpnd_pkg.
`default_nettype none

module lpnd_front
    import lpnd_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_accept,
    input  wire t_in_item i_item,
    input  wire logic     i_cfg_we,
    input  wire logic [2:0] i_cfg_data,
    output t_pair         o_pair,
    output logic          o_push
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [31:0] POS_MAX_32 = 32'(POS_MAX);

    t_phase                   r_phase, n_phase;
    logic [2:0]               r_pcnt, n_pcnt;
    logic [31:0]              r_accum, n_accum;
    logic [LENGTH_W-1:0]      r_left, n_left;
    logic [LENGTH_W-1:0]      r_got, n_got;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [POSITION_BITS-1:0] r_pstart, n_pstart;
    logic [POSITION_BITS-1:0] r_dstart, n_dstart;
    logic [7:0]               r_hdr, n_hdr;
    logic [POSITION_BITS-1:0] r_disc, n_disc;
    logic [2:0]               r_lfb;

    logic [2:0]               plen;
    logic [POSITION_BITS-1:0] pos_inc;
    logic [POSITION_BITS-1:0] disc_inc;
    logic [31:0]              acc_base;
    logic [31:0]              acc_new;
    logic [POSITION_BITS-1:0] start;
    logic [2:0]               cnt_new;
    logic [7:0]               hdr;
    logic [LENGTH_W-1:0]      got_new;
    logic [31:0]              got_sat;
    t_pair                    pair;
    logic                     push;

    assign plen     = prefix_len(r_lfb);
    assign pos_inc  = (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;
    assign disc_inc = (r_disc == POS_MAX) ? r_disc : r_disc + 1'b1;
    assign acc_base = (r_pcnt == 3'd0) ? 32'd0 : r_accum;
    assign acc_new  = {acc_base[23:0], i_item.data_byte};
    assign start    = (r_pcnt == 3'd0) ? r_pos : r_pstart;
    assign cnt_new  = r_pcnt + 3'd1;
    assign hdr      = (r_got == '0) ? i_item.data_byte : r_hdr;
    assign got_new  = r_got + 1'b1;
    assign got_sat  = (32'(got_new) > POS_MAX_32) ? POS_MAX_32 : 32'(got_new);

    always_comb begin
        n_phase  = r_phase;
        n_pcnt   = r_pcnt;
        n_accum  = r_accum;
        n_left   = r_left;
        n_got    = r_got;
        n_pos    = r_pos;
        n_pstart = r_pstart;
        n_dstart = r_dstart;
        n_hdr    = r_hdr;
        n_disc   = r_disc;
        pair     = '0;
        push     = 1'b0;
        if (i_accept) begin
            unique case (r_phase)
                PH_PREFIX: begin
                    n_pstart = start;
                    n_accum  = acc_new;
                    if (cnt_new >= plen) begin
                        n_pcnt   = 3'd0;
                        n_dstart = pos_inc;
                        if (acc_new == 32'd0 || acc_new[31]) begin
                            n_phase = PH_DISCARD;
                            n_disc  = '0;
                            if (i_item.packet_last) begin
                                push    = 1'b1;
                                pair.r0 = mk_result(K_INVALID, OFFSET_W'(start),
                                                    acc_new[LENGTH_W-1:0], 8'd0, '0);
                            end
                        end else begin
                            n_phase = PH_PAYLOAD;
                            n_left  = acc_new[LENGTH_W-1:0];
                            n_got   = '0;
                            if (i_item.packet_last) begin
                                push    = 1'b1;
                                pair.r0 = mk_result(K_EXCEEDS, OFFSET_W'(start),
                                                    acc_new[LENGTH_W-1:0], 8'd0, '0);
                            end
                        end
                    end else begin
                        n_pcnt = cnt_new;
                        if (i_item.packet_last) begin
                            push    = 1'b1;
                            pair.r0 = mk_result(K_TRUNC, OFFSET_W'(start), '0, 8'd0,
                                                OFFSET_W'(cnt_new));
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_hdr  = hdr;
                    n_left = r_left - 1'b1;
                    n_got  = got_new;
                    if (r_left == LENGTH_W'(1)) begin
                        push    = 1'b1;
                        pair.r0 = mk_result(K_UNIT, OFFSET_W'(r_dstart),
                                            r_accum[LENGTH_W-1:0], hdr, '0);
                        n_phase = PH_PREFIX;
                        n_accum = 32'd0;
                    end else if (i_item.packet_last) begin
                        push    = 1'b1;
                        pair.r0 = mk_result(K_EXCEEDS, OFFSET_W'(r_pstart),
                                            r_accum[LENGTH_W-1:0], 8'd0,
                                            OFFSET_W'(got_sat));
                        if (got_sat < 32'(plen)) begin
                            pair.two = 1'b1;
                            pair.r1  = mk_result(K_TRUNC, OFFSET_W'(r_dstart), '0, 8'd0,
                                                 OFFSET_W'(got_sat));
                        end
                    end
                end
                PH_DISCARD: begin
                    n_disc = disc_inc;
                    if (i_item.packet_last) begin
                        push    = 1'b1;
                        pair.r0 = mk_result(K_INVALID, OFFSET_W'(r_pstart),
                                            r_accum[LENGTH_W-1:0], 8'd0,
                                            OFFSET_W'(disc_inc));
                        if (32'(disc_inc) < 32'(plen)) begin
                            pair.two = 1'b1;
                            pair.r1  = mk_result(K_TRUNC, OFFSET_W'(r_dstart), '0, 8'd0,
                                                 OFFSET_W'(disc_inc));
                        end
                    end
                end
                default: begin
                    n_phase = PH_PREFIX;
                end
            endcase
            pair.r0.last = !pair.two;
            n_pos = pos_inc;
            if (i_item.packet_last) begin
                n_phase  = PH_PREFIX;
                n_pcnt   = 3'd0;
                n_accum  = 32'd0;
                n_left   = '0;
                n_got    = '0;
                n_pos    = '0;
                n_pstart = '0;
                n_dstart = '0;
                n_hdr    = 8'd0;
                n_disc   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_PREFIX;
            r_pcnt   <= 3'd0;
            r_accum  <= 32'd0;
            r_left   <= '0;
            r_got    <= '0;
            r_pos    <= '0;
            r_pstart <= '0;
            r_dstart <= '0;
            r_hdr    <= 8'd0;
            r_disc   <= '0;
            r_lfb    <= 3'd4;
        end else begin
            r_phase  <= n_phase;
            r_pcnt   <= n_pcnt;
            r_accum  <= n_accum;
            r_left   <= n_left;
            r_got    <= n_got;
            r_pos    <= n_pos;
            r_pstart <= n_pstart;
            r_dstart <= n_dstart;
            r_hdr    <= n_hdr;
            r_disc   <= n_disc;
            if (i_cfg_we) begin
                r_lfb <= i_cfg_data;
            end
        end
    end

    assign o_pair = pair;
    assign o_push = push;

endmodule

`default_nettype wire

### rtl/lpnd_queue.sv
// Short FIFO of result pairs between the front and back parts.
// Depends on lpnd_pkg.
`default_nettype none

module lpnd_queue
    import lpnd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_pair i_pair,
    input  wire logic  i_pop,
    output t_pair      o_pair,
    output t_qstat     o_stat
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_pair         r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_pair;
        end
    end

    assign o_pair = r_mem[r_rd];
    assign o_stat = {(r_cnt == '0), (r_cnt == CW'(QUEUE_DEPTH))};

endmodule

`default_nettype wire

### rtl/lpnd_back.sv
// Back part: pops result pairs and presents them one at a time through the
// output register. Depends on lpnd_pkg.
`default_nettype none

module lpnd_back
    import lpnd_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_qstat i_qstat,
    input  wire t_pair  i_pair,
    output logic        o_pop,
    output logic        o_valid,
    input  wire logic   i_stall,
    output t_result     o_data
);

    logic    r_valid, n_valid;
    t_result r_data, n_data;
    logic    r_pend_valid, n_pend_valid;
    t_result r_pend, n_pend;
    logic    free;
    logic    pop;

    assign free = !r_valid || !i_stall;

    always_comb begin
        n_valid      = r_valid;
        n_data       = r_data;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        pop          = 1'b0;
        if (free) begin
            priority if (r_pend_valid) begin
                n_valid      = 1'b1;
                n_data       = r_pend;
                n_pend_valid = 1'b0;
            end else if (!i_qstat.empty) begin
                pop          = 1'b1;
                n_valid      = 1'b1;
                n_data       = i_pair.r0;
                n_pend       = i_pair.r1;
                n_pend_valid = i_pair.two;
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_valid      <= n_valid;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_pend <= n_pend;
    end

    assign o_pop   = pop;
    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

### rtl/length_prefixed_nal_deframer.sv
// Length-prefixed NAL deframer, top level: front, pair queue and back part.
// Depends on lpnd_pkg, lpnd_front, lpnd_queue, lpnd_back.
//
// Usage: packet bytes enter on the input channel (i_in_valid / o_in_stall,
// payload t_in_item), one byte per transaction, packet_last on the final
// byte. Results leave on the output channel (o_out_valid / i_out_stall,
// payload t_result): one per complete unit, and error or truncation reports
// after the packet's last byte (up to two for that byte, the final one with
// last set). The prefix size register is written on i_cfg_valid / o_cfg_ready;
// the user must write it only while the block is idle, which the block does
// not enforce; o_cfg_ready is always high. Throughput: one byte per cycle;
// o_in_stall rises only when the four-entry pair queue is full. A byte's
// first result passes through the pair queue into the output register; a
// byte with two results presents the second from a pending register after
// the first is taken.
// Reset: all per-packet state clears, the prefix size returns to 4 and the
// output goes invalid. While the receiver stalls, the output result holds,
// the queue fills and input bytes are then held off.
`default_nettype none

module length_prefixed_nal_deframer
    import lpnd_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_in_item   i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_result         o_out_data,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [2:0] i_cfg_data
);

    t_pair  front_pair;
    logic   front_push;
    t_pair  q_pair;
    t_qstat q_stat;
    logic   q_pop;
    logic   accept;

    assign accept      = i_in_valid && !q_stat.full;
    assign o_in_stall  = q_stat.full;
    assign o_cfg_ready = 1'b1;

    lpnd_front #(
        .POSITION_BITS(POSITION_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_item    (i_in_data),
        .i_cfg_we  (i_cfg_valid),
        .i_cfg_data(i_cfg_data),
        .o_pair    (front_pair),
        .o_push    (front_push)
    );

    lpnd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (front_push),
        .i_pair (front_pair),
        .i_pop  (q_pop),
        .o_pair (q_pair),
        .o_stat (q_stat)
    );

    lpnd_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_qstat(q_stat),
        .i_pair (q_pair),
        .o_pop  (q_pop),
        .o_valid(o_out_valid),
        .i_stall(i_out_stall),
        .o_data (o_out_data)
    );

endmodule

`default_nettype wire

### rtl/lpnd_checker.sv
// Port-level checker for the deframer, bound to the top level.
// Depends on lpnd_pkg and length_prefixed_nal_deframer.
`default_nettype none

module lpnd_checker
    import lpnd_pkg::*;
(
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    o_out_valid,
    input wire logic    i_out_stall,
    input wire t_result o_out_data
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == K_UNIT |->
            o_out_data.remaining_bytes == '0 && o_out_data.unit_length != '0
            && o_out_data.last)
        else $error("malformed unit result");

    a_trunc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == K_TRUNC |->
            o_out_data.unit_length == '0 && o_out_data.last)
        else $error("malformed truncation report");

    a_err_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind != K_UNIT |->
            !o_out_data.forbidden_bit && o_out_data.ref_priority == 2'd0
            && o_out_data.unit_type == 5'd0)
        else $error("header fields on error report");

endmodule

bind length_prefixed_nal_deframer lpnd_checker u_lpnd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_data (o_out_data)
);

`default_nettype wire
